### hdl/stick_radial_deadzone_normalizer_top_macros.svh
// Assertion macros used by the assertion checker of this block (srdn_assert).
`ifndef STICK_RADIAL_DEADZONE_NORMALIZER_TOP_MACROS_SVH
`define STICK_RADIAL_DEADZONE_NORMALIZER_TOP_MACROS_SVH

// Same-cycle implication, inactive while reset is high.
`define SRDN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srdn assertion failed");

// Next-cycle implication, inactive while reset is high.
`define SRDN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srdn assertion failed");

// Next-cycle implication that also holds across reset.
`define SRDN_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("srdn assertion failed");

`endif

### hdl/srdn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdn_pkg
// Types, constants and the search step shared by the stick normalizer.
// ----------------------------------------------------------------------------
package srdn_pkg;

  // Fraction bits of the normalized outputs.
  localparam int OUT_FRAC_BITS = 15;
  // One search cell per result bit, the top one included.
  localparam int STEPS = OUT_FRAC_BITS + 1;
  localparam int QW    = OUT_FRAC_BITS + 1;
  // Width of the running sums in the search cells.
  localparam int WW    = 2 * OUT_FRAC_BITS + 34;
  // Width of the signed remaining-distance track.
  localparam int DW    = OUT_FRAC_BITS + 9;
  localparam int OUT_LIM = (OUT_FRAC_BITS >= 15) ? 32767 : ((1 << OUT_FRAC_BITS) - 1);

  localparam logic [6:0]  AXIS_FULL   = 7'd127;
  localparam logic [7:0]  AXIS_CENTRE = 8'd127;
  localparam logic [6:0]  PCT_MAX     = 7'd100;
  localparam logic [15:0] FULL_SQ     = 16'd16129;
  // floor(x / 100) as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x below 2^14.
  localparam logic [26:0] DIV100_MUL  = 27'd5243;
  localparam int          DIV100_SHIFT = 19;

  typedef struct packed {
    logic [7:0] raw_x;
    logic [7:0] raw_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic               in_deadzone;
  } out_t;

  // Search state of one axis.
  typedef struct packed {
    logic                 neg;
    logic [QW-1:0]        bitv;
    logic [QW-1:0]        q;
    logic signed [WW-1:0] w;
    logic signed [WW-1:0] h;
    logic signed [WW-1:0] g;
    logic signed [WW-1:0] r;
    logic signed [DW-1:0] bk;
    logic signed [DW-1:0] diff;
  } axis_t;

  // What one cell hands to the next.
  typedef struct packed {
    logic  valid;
    logic  dz;
    logic  clipped;
    axis_t x;
    axis_t y;
  } cell_t;

  // One bit of the result search: try setting the current bit, keep it if the
  // scaled value still reaches the trial, then rescale the increments.
  function automatic axis_t axis_step(axis_t a, logic clipped);
    axis_t                o;
    logic signed [WW-1:0] wt;
    logic signed [DW-1:0] dt;
    logic                 ok;
    o  = a;
    wt = $signed(a.w) + $signed(a.h) + $signed(a.g);
    dt = $signed(a.diff) - $signed(a.bk);
    if (clipped) begin
      ok = ($signed(wt) <= $signed(a.r));
    end else begin
      ok = !dt[DW-1] && ($signed(wt) >= $signed(a.r));
    end
    if (ok) begin
      o.w    = wt;
      o.diff = dt;
      o.h    = $signed(a.h) + ($signed(a.g) <<< 1);
      o.q    = a.q | a.bitv;
    end
    o.h    = $signed(o.h) >>> 1;
    o.g    = $signed(a.g) >>> 2;
    o.bk   = $signed(a.bk) >>> 1;
    o.bitv = a.bitv >> 1;
    return o;
  endfunction

endpackage

### hdl/srdn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdn_front
// Three setup stages: centering, magnitude and deadzone test, and the
// products that seed the search cells.
// ----------------------------------------------------------------------------
module srdn_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  srdn_pkg::in_t   in_data,
  input  logic [6:0]      pct,
  output srdn_pkg::cell_t seed
);
  import srdn_pkg::*;

  // Stage 0 logic: deadzone radius and centered axes.
  logic [6:0]  pct_c;
  logic [13:0] pct_x;
  logic [6:0]  rad;
  logic [7:0]  ax0, ay0;
  logic        nx0, ny0;

  always_comb begin
    pct_c = (pct > PCT_MAX) ? PCT_MAX : pct;
    pct_x = 14'(pct_c) * 14'(AXIS_FULL);
    rad   = 7'((27'(pct_x) * DIV100_MUL) >> DIV100_SHIFT);
    nx0   = in_data.raw_x < AXIS_CENTRE;
    ax0   = nx0 ? (AXIS_CENTRE - in_data.raw_x) : (in_data.raw_x - AXIS_CENTRE);
    ny0   = in_data.raw_y > AXIS_CENTRE;
    ay0   = ny0 ? (in_data.raw_y - AXIS_CENTRE) : (AXIS_CENTRE - in_data.raw_y);
  end

  // Stage 1 registers.
  logic        v1, nx1, ny1;
  logic [7:0]  ax1, ay1;
  logic [15:0] s1;
  logic [6:0]  d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1 <= nx0;
      ny1 <= ny0;
      ax1 <= ax0;
      ay1 <= ay0;
      s1  <= 16'(16'(ax0) * 16'(ax0) + 16'(ay0) * 16'(ay0));
      d1  <= rad;
    end
  end

  // Stage 2 registers: deadzone test and first products.
  logic        v2, dz2, clip2, nx2, ny2;
  logic [7:0]  ax2, ay2;
  logic [15:0] s2, d2x2, d2y2;
  logic [6:0]  b2;
  logic [13:0] bb2;
  logic [23:0] dsx2, dsy2;
  logic [14:0] ddx2, ddy2;
  logic [6:0]  b1;

  assign b1 = AXIS_FULL - d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz2   <= (d1 == AXIS_FULL) || (s1 <= 16'(14'(d1) * 14'(d1)));
      clip2 <= s1 >= FULL_SQ;
      nx2   <= nx1;
      ny2   <= ny1;
      ax2   <= ax1;
      ay2   <= ay1;
      s2    <= s1;
      b2    <= b1;
      bb2   <= 14'(b1) * 14'(b1);
      dsx2  <= 24'(ax1) * 24'(s1);
      dsy2  <= 24'(ay1) * 24'(s1);
      d2x2  <= 16'(ax1) * 16'(ax1);
      d2y2  <= 16'(ay1) * 16'(ay1);
      ddx2  <= 15'(ax1) * 15'(d1);
      ddy2  <= 15'(ay1) * 15'(d1);
    end
  end

  // Stage 3 registers: second products.
  logic        v3, dz3, clip3, nx3, ny3;
  logic [7:0]  ax3, ay3;
  logic [6:0]  b3;
  logic [15:0] s3, d2x3, d2y3;
  logic [30:0] bdsx3, bdsy3;
  logic [31:0] d2sx3, d2sy3;
  logic [29:0] dd2x3, dd2y3, gs3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz3   <= dz2;
      clip3 <= clip2;
      nx3   <= nx2;
      ny3   <= ny2;
      ax3   <= ax2;
      ay3   <= ay2;
      b3    <= b2;
      s3    <= s2;
      d2x3  <= d2x2;
      d2y3  <= d2y2;
      bdsx3 <= 31'(b2) * 31'(dsx2);
      bdsy3 <= 31'(b2) * 31'(dsy2);
      d2sx3 <= 32'(d2x2) * 32'(s2);
      d2sy3 <= 32'(d2y2) * 32'(s2);
      dd2x3 <= 30'(ddx2) * 30'(ddx2);
      dd2y3 <= 30'(ddy2) * 30'(ddy2);
      gs3   <= 30'(bb2) * 30'(s2);
    end
  end

  // Starting point of the bit search for one axis.
  function automatic axis_t seed_axis(logic [7:0] a, logic neg, logic clipped,
                                      logic [6:0] b, logic [15:0] s,
                                      logic [15:0] d2, logic [30:0] bds,
                                      logic [31:0] d2s, logic [29:0] dd2,
                                      logic [29:0] gs);
    axis_t o;
    o.neg  = neg;
    o.bitv = QW'(1) << OUT_FRAC_BITS;
    o.q    = '0;
    if (clipped) begin
      o.w    = '0;
      o.h    = '0;
      o.g    = WW'(s) <<< (2 * OUT_FRAC_BITS);
      o.r    = WW'(d2) <<< (2 * OUT_FRAC_BITS);
      o.bk   = '0;
      o.diff = '0;
    end else begin
      o.w    = WW'(d2s) <<< (2 * OUT_FRAC_BITS);
      o.h    = -(WW'(bds) <<< (2 * OUT_FRAC_BITS + 1));
      o.g    = WW'(gs) <<< (2 * OUT_FRAC_BITS);
      o.r    = WW'(dd2) <<< (2 * OUT_FRAC_BITS);
      o.bk   = DW'(b) <<< OUT_FRAC_BITS;
      o.diff = DW'(a) <<< OUT_FRAC_BITS;
    end
    return o;
  endfunction

  always_comb begin
    seed.valid   = v3;
    seed.dz      = dz3;
    seed.clipped = clip3;
    seed.x = seed_axis(ax3, nx3, clip3, b3, s3, d2x3, bdsx3, d2sx3, dd2x3, gs3);
    seed.y = seed_axis(ay3, ny3, clip3, b3, s3, d2y3, bdsy3, d2sy3, dd2y3, gs3);
  end

endmodule

### hdl/srdn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdn_cell
// One search cell: settles one result bit of both axes and passes on.
// ----------------------------------------------------------------------------
module srdn_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  srdn_pkg::cell_t prev,
  output srdn_pkg::cell_t next
);
  import srdn_pkg::*;

  logic  vld;
  logic  dz, clipped;
  axis_t xs, ys;

  // Valid bit of the beat held in this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= prev.valid;
    end
  end

  // Trial of this bit on both axes.
  always_ff @(posedge clk) begin
    if (en) begin
      dz      <= prev.dz;
      clipped <= prev.clipped;
      xs      <= axis_step(prev.x, prev.clipped);
      ys      <= axis_step(prev.y, prev.clipped);
    end
  end

  always_comb begin
    next.valid   = vld;
    next.dz      = dz;
    next.clipped = clipped;
    next.x       = xs;
    next.y       = ys;
  end

endmodule

### hdl/stick_radial_deadzone_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_radial_deadzone_normalizer_top
// Circular deadzone and radial rescale of one analog stick sample.
// ----------------------------------------------------------------------------
// Usage:
//   A beat on in_valid/in_ready carries one raw stick sample (raw_x, raw_y).
//   A beat on out_valid/out_ready returns norm_x, norm_y (signed Q1.15) and
//   in_deadzone for that sample, in the order the samples came in.
//   cfg_wen writes cfg_wdata into the deadzone percent at once; write it
//   only while no sample is in flight.
//   Each sample passes three setup stages, one search cell per result bit
//   (16), and the output register.
//   Throughput is one sample per cycle unless stalled; the chain of search
//   cells is fully pipelined and each cell settles one bit of both axes.
//   When the receiver stalls with a result waiting, the whole chain holds and
//   in_ready drops until the waiting beat is taken.
//   Synchronous reset empties the chain and sets the deadzone to zero.
// ----------------------------------------------------------------------------
module stick_radial_deadzone_normalizer_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  srdn_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output srdn_pkg::out_t out_data,
  input  logic           cfg_wen,
  input  logic [6:0]     cfg_wdata
);
  import srdn_pkg::*;

  logic  en;
  logic  [6:0] pct;
  cell_t link [STEPS+1];

  // The chain moves whenever the output register is free or being taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Deadzone percent register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= '0;
    end else if (cfg_wen) begin
      pct <= cfg_wdata;
    end
  end

  srdn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .pct      (pct),
    .seed     (link[0])
  );

  // Row of search cells, most significant bit first.
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    srdn_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (link[i]),
      .next (link[i+1])
    );
  end

  // Saturate and apply the sign of one axis, or give zero inside the deadzone.
  function automatic logic signed [15:0] finish_axis(axis_t a, logic dz);
    logic [15:0] mag;
    mag = (a.q > QW'(OUT_LIM)) ? 16'(OUT_LIM) : 16'(a.q);
    if (dz) begin
      return '0;
    end
    return a.neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= link[STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.norm_x      <= finish_axis(link[STEPS].x, link[STEPS].dz);
      out_data.norm_y      <= finish_axis(link[STEPS].y, link[STEPS].dz);
      out_data.in_deadzone <= link[STEPS].dz;
    end
  end

endmodule

### hdl/srdn_assert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdn_assert
// Port-level checks of the stick normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "stick_radial_deadzone_normalizer_top_macros.svh"

module srdn_assert (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input srdn_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input srdn_pkg::out_t out_data
);
  import srdn_pkg::*;

  // A stalled input beat stays on offer with the same sample.
  `SRDN_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

  // A stalled result beat stays on offer.
  `SRDN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A sample inside the deadzone gives zero on both axes.
  `SRDN_ASSERT_NOW(a_dz_zero, out_valid && out_data.in_deadzone, out_data[32:1] == '0)

  // Saturation is symmetric, so the most negative code never shows.
  `SRDN_ASSERT_NOW(a_sym_sat, out_valid, (out_data.norm_x != -16'sd32768) && (out_data.norm_y != -16'sd32768))

  // Reset empties the pipeline.
  `SRDN_ASSERT_NEXT_ALWAYS(a_rst_empty, rst, !out_valid)

endmodule

bind stick_radial_deadzone_normalizer_top srdn_assert u_srdn_assert (.*);

### test/srdn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdn_checker
// Watches both channels and the deadzone register of the stick normalizer,
// works out the exact normalized sample for every input beat, and compares
// each output beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module srdn_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  srdn_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  srdn_pkg::out_t out_data,
  input  logic           cfg_wen,
  input  logic [6:0]     cfg_wdata,
  output int             fails,
  output int             pending
);
  import srdn_pkg::*;

  localparam int FRAC = OUT_FRAC_BITS;
  localparam longint unsigned SAT = OUT_LIM;

  logic [6:0] dz_pct;
  out_t       norm_q[$];

  // Largest q with q <= |dv| * 2^FRAC * (min(127,m) - r) / ((127 - r) * m).
  function automatic logic signed [15:0] axis_norm(int dv, longint unsigned sq,
                                                   longint unsigned r, bit clip);
    longint unsigned a, lo, hi, mid, qb, gap, q;
    logic [127:0]    lhs, rhs;
    bit              ok;
    a  = longint'(dv < 0 ? -dv : dv) << FRAC;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (clip) begin
        ok = (mid * mid * sq) <= (a * a);
      end else begin
        qb = mid * (127 - r);
        if (qb > a) begin
          ok = 0;
        end else begin
          gap = a - qb;
          lhs = 128'(gap) * 128'(gap) * 128'(sq);
          rhs = 128'(a * r) * 128'(a * r);
          ok  = lhs >= rhs;
        end
      end
      if (ok) lo = mid;
      else hi = mid - 1;
    end
    q = (lo > SAT) ? SAT : lo;
    if (dv < 0) return -$signed(16'(q));
    return 16'(q);
  endfunction

  function automatic out_t norm_sample(in_t smp, logic [6:0] pct_reg);
    out_t            res;
    int              dx, dy;
    longint unsigned pct, r, sq;
    dx  = int'(smp.raw_x) - 127;
    dy  = 127 - int'(smp.raw_y);
    pct = (pct_reg > 100) ? 100 : pct_reg;
    r   = (127 * pct) / 100;
    sq  = longint'(dx * dx + dy * dy);
    res = '0;
    if (r >= 127 || sq <= r * r) begin
      res.in_deadzone = 1'b1;
    end else begin
      res.norm_x = axis_norm(dx, sq, r, sq >= 16129);
      res.norm_y = axis_norm(dy, sq, r, sq >= 16129);
    end
    return res;
  endfunction

  assign pending = norm_q.size();

  // Track the register, queue predictions, and check output beats.
  always_ff @(posedge clk) begin
    out_t want;
    if (rst) begin
      dz_pct <= '0;
      fails  <= 0;
      norm_q.delete();
    end else begin
      if (cfg_wen) dz_pct <= cfg_wdata;
      if (in_valid && in_ready) norm_q.push_back(norm_sample(in_data, dz_pct));
      if (out_valid && out_ready) begin
        if (norm_q.size() == 0) begin
          if (fails < 10) $display("unexpected output beat %p", out_data);
          fails <= fails + 1;
        end else begin
          want = norm_q.pop_front();
          if (want.norm_x !== out_data.norm_x || want.norm_y !== out_data.norm_y ||
              want.in_deadzone !== out_data.in_deadzone) begin
            if (fails < 10)
              $display("mismatch: expected x=%0d y=%0d dz=%0b, got x=%0d y=%0d dz=%0b",
                       want.norm_x, want.norm_y, want.in_deadzone,
                       out_data.norm_x, out_data.norm_y, out_data.in_deadzone);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives stick samples through the radial deadzone normalizer over a range
// of deadzone settings, with random idle bursts on both channels, and lets
// the checker judge every output beat.
// ----------------------------------------------------------------------------
module tb;
  import srdn_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_wen = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic       in_fire = 1'b0;
  bit         quiet = 0;
  int         fails, pending;
  int         stall_left = 0;

  always #6 clk = ~clk;

  stick_radial_deadzone_normalizer_top u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  srdn_checker u_chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata), .fails(fails), .pending(pending)
  );

  // Registered record of an accepted input beat, read at the falling edge.
  always @(posedge clk) in_fire <= in_valid && in_ready;

  // Receiver: random stall bursts, none in the last part.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one sample and hold it until the beat is taken.
  task automatic send_sample(logic [7:0] x, logic [7:0] y);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{raw_x: x, raw_y: y};
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic set_deadzone(logic [6:0] pct);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (25) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= pct;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  logic [6:0] settings[10] = '{7'd0, 7'd100, 7'd127, 7'd1, 7'd50,
                               7'd25, 7'd99, 7'd10, 7'd75, 7'd64};
  logic [7:0] corner_x[11] = '{8'd127, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                               8'd255, 8'd127, 8'd127, 8'd128, 8'd126};
  logic [7:0] corner_y[11] = '{8'd127, 8'd0, 8'd255, 8'd255, 8'd0, 8'd127,
                               8'd127, 8'd0, 8'd255, 8'd127, 8'd127};

  initial begin
    logic [7:0] rx, ry;
    int         phase, k;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (phase = 0; phase < 10; phase++) begin
      // The first phase runs at the reset value of the register.
      if (phase > 0) set_deadzone(settings[phase]);
      for (k = 0; k < 11; k++) send_sample(corner_x[k], corner_y[k]);
      if (phase == 9) quiet = 1;
      for (k = 0; k < 130; k++) begin
        case ($urandom_range(0, 3))
          0: begin
            rx = 8'(127 + $urandom_range(0, 60) - 30);
            ry = 8'(127 + $urandom_range(0, 60) - 30);
          end
          1: begin
            rx = $urandom_range(0, 1) ? 8'($urandom_range(0, 10)) : 8'($urandom_range(245, 255));
            ry = 8'($urandom_range(0, 255));
          end
          default: begin
            rx = 8'($urandom_range(0, 255));
            ry = 8'($urandom_range(0, 255));
          end
        endcase
        send_sample(rx, ry);
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
